// ===== hdl/fcd_pkg.sv =====
// fcd_pkg: types and constants shared by the foot contact detector.
// Holds the request structs, configuration register codes and fixed widths.
// No dependencies.
package fcd_pkg;

  localparam int FORCE_W    = 24;
  localparam int ALPHA_W    = 17;
  localparam int RATIO_W    = 17;
  localparam int TIME_W     = 32;
  localparam int MIN_CNT_W  = 8;
  localparam int NUM_LEGS   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ALPHA      = 3'd0,
    CFG_THRESHOLD_ON      = 3'd1,
    CFG_THRESHOLD_OFF     = 3'd2,
    CFG_MIN_CONTACT_COUNT = 3'd3,
    CFG_MIN_SWING_COUNT   = 3'd4,
    CFG_DETECT_RATIO      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [FORCE_W-1:0] leg0_force;
    logic signed [FORCE_W-1:0] leg1_force;
    logic signed [FORCE_W-1:0] leg2_force;
    logic signed [FORCE_W-1:0] leg3_force;
    logic [NUM_LEGS-1:0]       stance_mask;
    logic                      schedule_valid;
    logic [TIME_W-1:0]         phase_elapsed;
    logic [TIME_W-1:0]         phase_length;
  } in_item_t;

  typedef struct packed {
    logic [NUM_LEGS-1:0] contact_mask;
    logic                detect_active;
  } out_item_t;

  // Settings every leg needs, alpha already clamped to one
  typedef struct packed {
    logic [ALPHA_W-1:0]        alpha;
    logic signed [FORCE_W-1:0] thr_on;
    logic signed [FORCE_W-1:0] thr_off;
    logic [MIN_CNT_W-1:0]      min_contact;
    logic [MIN_CNT_W-1:0]      min_swing;
  } leg_cfg_t;

endpackage

// ===== hdl/fcd_phase_gate.sv =====
// fcd_phase_gate: second pipeline stage, decides whether the gait phase has
// progressed past the detection ratio and holds the request. Uses fcd_pkg.
module fcd_phase_gate (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  fcd_pkg::in_item_t         item_i,
  input  logic [fcd_pkg::RATIO_W-1:0] ratio_i,
  output fcd_pkg::in_item_t         item_o,
  output logic                      active_o
);
  import fcd_pkg::*;

  localparam int PROD_W = RATIO_W + TIME_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] elapsed_scaled;
  logic              reached;
  logic              active_d, active_q;
  in_item_t          item_q;

  // elapsed * 65536 >= ratio * length; zero length counts as reached
  assign prod           = PROD_W'(ratio_i) * PROD_W'(item_i.phase_length);
  assign elapsed_scaled = PROD_W'({item_i.phase_elapsed, 16'h0000});
  assign reached        = (item_i.phase_length == '0) || (elapsed_scaled >= prod);
  assign active_d       = item_i.schedule_valid && reached;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (en_i) begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
    end
  end

  assign item_o   = item_q;
  assign active_o = active_q;

endmodule

// ===== hdl/fcd_leg.sv =====
// fcd_leg: per-leg state: exponential force filter, hysteresis compare,
// saturating debounce counters and the contact flag. Uses fcd_pkg.
module fcd_leg #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             stance_i,
  input  logic                             active_i,
  input  logic signed [fcd_pkg::FORCE_W-1:0] force_i,
  input  fcd_pkg::leg_cfg_t                cfg_i,
  output logic                             flag_o
);
  import fcd_pkg::*;

  localparam int DIFF_W = FORCE_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int CMP_W  = (COUNT_WIDTH > MIN_CNT_W) ? COUNT_WIDTH : MIN_CNT_W;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  logic signed [FORCE_W-1:0] filt_q, filt_d, filt_new;
  logic [COUNT_WIDTH-1:0]    crun_q, crun_d, crun_new;
  logic [COUNT_WIDTH-1:0]    srun_q, srun_d, srun_new;
  logic                      flag_q, flag_d;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ALPHA_W:0]   alpha_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  step;
  logic                      cand_on, cand_off;

  // y' = y + round(alpha * (f - y) / 65536), same as the convex blend
  assign diff     = DIFF_W'(force_i) - DIFF_W'(filt_q);
  assign alpha_s  = $signed({1'b0, cfg_i.alpha});
  assign prod     = PROD_W'(alpha_s) * PROD_W'(diff);
  assign step     = (prod + ROUND_HALF) >>> 16;
  assign filt_new = filt_q + step[FORCE_W-1:0];

  assign cand_on  = (filt_new >= cfg_i.thr_on);
  assign cand_off = (filt_new <= cfg_i.thr_off);

  always_comb begin
    crun_new = '0;
    srun_new = '0;
    if (cand_on) begin
      crun_new = (crun_q == '1) ? crun_q : crun_q + 1'b1;
    end else if (cand_off) begin
      srun_new = (srun_q == '1) ? srun_q : srun_q + 1'b1;
    end
  end

  always_comb begin
    filt_d = filt_q;
    crun_d = '0;
    srun_d = '0;
    flag_d = flag_q;
    if (stance_i) begin
      flag_d = 1'b1;
    end else if (!active_i) begin
      flag_d = 1'b0;
    end else begin
      filt_d = filt_new;
      crun_d = crun_new;
      srun_d = srun_new;
      if (CMP_W'(crun_new) >= CMP_W'(cfg_i.min_contact)) begin
        flag_d = 1'b1;
      end else if (CMP_W'(srun_new) >= CMP_W'(cfg_i.min_swing)) begin
        flag_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      crun_q <= '0;
      srun_q <= '0;
      flag_q <= 1'b0;
    end else if (en_i) begin
      filt_q <= filt_d;
      crun_q <= crun_d;
      srun_q <= srun_d;
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;

endmodule

// ===== hdl/foot_contact_detector.sv =====
// foot_contact_detector: top level of the four-leg contact estimator.
// Depends on fcd_pkg, fcd_phase_gate and fcd_leg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   in      | request   | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
//   out     | result    | out_valid_o / out_ready_i| out_data_o (out_item_t)
//   cfg     | write     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Throughput is one request per cycle while no result is stalled. A request
// passes the input register, the phase gate register (the ratio times length
// multiply), then the leg update that writes the state, result and out_valid_o.
// The leg filter multiply, threshold compare and debounce set the cycle path.
// Reset clears all leg state and loads the register defaults; no sweep needed.
// A stalled result holds the stages behind it once they fill; cfg_ready_o is tied high.
module foot_contact_detector #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  fcd_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output fcd_pkg::out_item_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import fcd_pkg::*;

  // Configuration registers
  logic [ALPHA_W-1:0]        alpha_q;
  logic signed [FORCE_W-1:0] thr_on_q;
  logic signed [FORCE_W-1:0] thr_off_q;
  logic [MIN_CNT_W-1:0]      min_contact_q;
  logic [MIN_CNT_W-1:0]      min_swing_q;
  logic [RATIO_W-1:0]        ratio_q;
  leg_cfg_t                  leg_cfg;

  // Pipeline control
  logic      s1_valid_q, s2_valid_q, s3_valid_q;
  logic      s2_ready, s3_ready;
  logic      s1_load, s2_load, s3_load;
  in_item_t  s1_item_q;
  in_item_t  s2_item;
  logic      s2_active;
  logic      active_q;
  logic [NUM_LEGS-1:0] flags;
  logic signed [FORCE_W-1:0] leg_force [NUM_LEGS];

  assign cfg_ready_o = 1'b1;

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q       <= ALPHA_W'(16384);
      thr_on_q      <= FORCE_W'(10240);
      thr_off_q     <= FORCE_W'(5120);
      min_contact_q <= MIN_CNT_W'(3);
      min_swing_q   <= MIN_CNT_W'(3);
      ratio_q       <= RATIO_W'(45875);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FILTER_ALPHA:      alpha_q       <= cfg_data_i[ALPHA_W-1:0];
        CFG_THRESHOLD_ON:      thr_on_q      <= cfg_data_i[FORCE_W-1:0];
        CFG_THRESHOLD_OFF:     thr_off_q     <= cfg_data_i[FORCE_W-1:0];
        CFG_MIN_CONTACT_COUNT: min_contact_q <= cfg_data_i[MIN_CNT_W-1:0];
        CFG_MIN_SWING_COUNT:   min_swing_q   <= cfg_data_i[MIN_CNT_W-1:0];
        CFG_DETECT_RATIO:      ratio_q       <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp alpha above one down to one
  always_comb begin
    leg_cfg.alpha       = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
    leg_cfg.thr_on      = thr_on_q;
    leg_cfg.thr_off     = thr_off_q;
    leg_cfg.min_contact = min_contact_q;
    leg_cfg.min_swing   = min_swing_q;
  end

  // Each stage advances when the stage after it has room
  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;

  assign s1_load = in_ready_o;
  assign s2_load = s2_ready;
  assign s3_load = s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_load) s1_valid_q <= in_valid_i;
      if (s2_load) s2_valid_q <= s1_valid_q;
      if (s3_load) s3_valid_q <= s2_valid_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  // Phase progress test, registered as stage two
  fcd_phase_gate u_gate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s2_load && s1_valid_q),
    .item_i   (s1_item_q),
    .ratio_i  (ratio_q),
    .item_o   (s2_item),
    .active_o (s2_active)
  );

  assign leg_force[0] = s2_item.leg0_force;
  assign leg_force[1] = s2_item.leg1_force;
  assign leg_force[2] = s2_item.leg2_force;
  assign leg_force[3] = s2_item.leg3_force;

  // Leg state moves only as a request enters the result stage, so the flags
  // themselves serve as the result register for contact_mask
  for (genvar g = 0; g < NUM_LEGS; g++) begin : g_leg
    fcd_leg #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_leg (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (s3_load && s2_valid_q),
      .stance_i (s2_item.stance_mask[g]),
      .active_i (s2_active),
      .force_i  (leg_force[g]),
      .cfg_i    (leg_cfg),
      .flag_o   (flags[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (s3_load && s2_valid_q) begin
      active_q <= s2_active;
    end
  end

  assign out_valid_o              = s3_valid_q;
  assign out_data_o.contact_mask  = flags;
  assign out_data_o.detect_active = active_q;

endmodule

// ===== hdl/fcd_checker.sv =====
// fcd_checker: port-level checks for foot_contact_detector, attached by bind.
// Tracks requests in flight against the three-stage pipeline. Uses fcd_pkg.
module fcd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input fcd_pkg::out_item_t             out_data_o
);
  import fcd_pkg::*;

  logic [2:0] inflight_q, inflight_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) inflight_d = inflight_q + 3'd1;
    if (!in_acc && out_acc) inflight_d = inflight_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // Never show a result without a request behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without request");

  // Three stages full and output stalled: stop taking requests
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 3'd3 && !out_ready_i |-> !in_ready_o)
    else $error("request taken with pipeline full");

  // Never exceed the pipeline depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("too many requests in flight");

endmodule

bind foot_contact_detector fcd_checker u_fcd_checker (.*);
